@@ design/coding_unit_index_map_defines.svh @@
// Assertion macros shared by the coding unit index map design.
// CUIM_ASSERT is switched off while rst is high; CUIM_ASSERT_RST also checks during reset.
`ifndef CODING_UNIT_INDEX_MAP_DEFINES_SVH
`define CODING_UNIT_INDEX_MAP_DEFINES_SVH
`ifndef SYNTHESIS
`define CUIM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CUIM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CUIM_ASSERT(lbl, prop, msg)
`define CUIM_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ design/cuim_pkg.sv @@
package cuim_pkg;

  // Field widths.
  localparam int COORD_W = 16;
  localparam int LOG2_W  = 3;
  localparam int UNIT_W  = 6;
  localparam int REQ_W   = 2;
  localparam int CFG_IDX_W = 2;

  // The present bits are kept eight to a memory row.
  localparam int PRES_ROW_W = 8;
  localparam int PRES_SEL_W = 3;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_LOG2  = 2'd3;

  // Register reset values.
  localparam logic [LOG2_W-1:0] BLOCK_LOG2_RESET = 3'd6;
  localparam logic [LOG2_W-1:0] CELL_LOG2_RESET  = 3'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PREP,
    ST_FILL,
    ST_LREAD,
    ST_LPRES
  } state_t;

endpackage

@@ design/cuim_ram.sv @@
module cuim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/coding_unit_index_map.sv @@
// Coding unit index map for one coding tree block.
// A request beat is taken at a rising edge with start high and busy low. Type add
// writes a unit number into every grid cell the unit covers, type lookup returns
// the number in the cell at a position, type clear empties the map.
// Each request gives exactly one result beat: done is high for one cycle with
// accepted, found, found_number and outside_block; fields that do not belong to the
// request type are zero. The receiver cannot stall; the next request may be taken
// at the edge that ends the done cycle.
// How each request runs:
//   add inside the block: R grid rows are read and written back, R from 1 to
//     CELLS_PER_SIDE, or none when the corner lies past the grid; one map row is
//     read and written back per cycle, each write overlapping the next row's read.
//   add rejected: no memory access.  lookup: the map row is read, then the present
//     row, with no read when outside the block or beyond the grid.
//   clear and undefined types: answered from the idle state without memory access.
// Configuration beats (cfg_valid, cfg_ready always high) go to the four registers.
// Reset, like clear, drops the row valid bits of both memories at once, so
// no clearing pass follows; registers return to origin 0, block 64, cell 8.
`include "coding_unit_index_map_defines.svh"

module coding_unit_index_map #(
  parameter int CELLS_PER_SIDE = 8,
  parameter int MAX_UNITS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // Request channel.
  input  logic                              start,
  output logic                              busy,
  input  logic [cuim_pkg::REQ_W-1:0]        req_type,
  input  logic [cuim_pkg::COORD_W-1:0]      pos_x,
  input  logic [cuim_pkg::COORD_W-1:0]      pos_y,
  input  logic [cuim_pkg::LOG2_W-1:0]       unit_log2_size,
  input  logic [cuim_pkg::UNIT_W-1:0]       unit_number,
  // Result channel.
  output logic                              done,
  output logic                              accepted,
  output logic                              found,
  output logic [cuim_pkg::UNIT_W-1:0]       found_number,
  output logic                              outside_block,
  // Configuration channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cuim_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cuim_pkg::COORD_W-1:0]      cfg_data
);

  localparam int ROW_W = (CELLS_PER_SIDE > 1) ? $clog2(CELLS_PER_SIDE) : 1;
  localparam int CNT_W = $clog2(CELLS_PER_SIDE + 1);
  localparam int ROW_BITS = CELLS_PER_SIDE * cuim_pkg::UNIT_W;
  localparam int PROWS = (MAX_UNITS + cuim_pkg::PRES_ROW_W - 1) / cuim_pkg::PRES_ROW_W;
  localparam int PROW_W = (PROWS > 1) ? $clog2(PROWS) : 1;
  localparam logic [7:0] CPS8 = 8'(CELLS_PER_SIDE);
  localparam logic [CNT_W-1:0] CPS_C = CNT_W'(CELLS_PER_SIDE);

  // Configuration registers.
  logic [cuim_pkg::COORD_W-1:0] origin_x;
  logic [cuim_pkg::COORD_W-1:0] origin_y;
  logic [cuim_pkg::LOG2_W-1:0]  block_log2;
  logic [cuim_pkg::LOG2_W-1:0]  cell_log2;

  // Sequencer and request registers.
  cuim_pkg::state_t state, state_next;
  logic [cuim_pkg::REQ_W-1:0]   req_q;
  logic [cuim_pkg::COORD_W-1:0] px_q, py_q;
  logic [cuim_pkg::LOG2_W-1:0]  ulog2_q;
  logic [cuim_pkg::UNIT_W-1:0]  num_q;
  logic [6:0]                   dx_q, dx_next, dy_q, dy_next;
  logic [CNT_W-1:0]             row_cur, row_cur_next, row_end, row_end_next;
  logic [CELLS_PER_SIDE-1:0]    col_mask, col_mask_next;
  logic [ROW_W-1:0]             row_q, row_q_next, col_q, col_q_next;
  logic                         wr_pend, wr_pend_next;
  logic                         pres_pend, pres_pend_next;
  logic [cuim_pkg::UNIT_W-1:0]  n_q, n_next;

  // Row valid bits: a row that is not valid reads as all zero.
  logic [CELLS_PER_SIDE-1:0]    map_valid;
  logic [PROWS-1:0]             pres_valid;

  // Result next values.
  logic                         done_next, accepted_next, found_next, outside_next;
  logic [cuim_pkg::UNIT_W-1:0]  found_number_next;
  logic                         clear_all;

  // Memory ports.
  logic                         map_we;
  logic [ROW_W-1:0]             map_waddr, map_raddr;
  logic [ROW_BITS-1:0]          map_wdata, map_rdata;
  logic                         pres_we;
  logic [PROW_W-1:0]            pres_waddr, pres_raddr;
  logic [cuim_pkg::PRES_ROW_W-1:0] pres_wdata, pres_rdata;

  // Combinational helpers.
  logic                         take;
  logic [7:0]                   usize, bsize, count, cx_end, cy_end;
  logic [cuim_pkg::COORD_W:0]   x_end, y_end, blk_x_end, blk_y_end;
  logic                         lo_ok, add_fit, look_fit;
  logic [cuim_pkg::COORD_W-1:0] diff_x, diff_y;
  logic [6:0]                   cx, cy;
  logic [ROW_BITS-1:0]          row_old, row_new;
  logic [cuim_pkg::UNIT_W-1:0]  entry;
  logic [PROW_W-1:0]            num_prow, entry_prow, n_prow;

  assign take      = start && !busy;
  assign busy      = (state != cuim_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign num_prow   = PROW_W'(num_q >> cuim_pkg::PRES_SEL_W);
  assign n_prow     = PROW_W'(n_q >> cuim_pkg::PRES_SEL_W);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      block_log2 <= cuim_pkg::BLOCK_LOG2_RESET;
      cell_log2  <= cuim_pkg::CELL_LOG2_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cuim_pkg::CFG_ORIGIN_X:   origin_x   <= cfg_data;
        cuim_pkg::CFG_ORIGIN_Y:   origin_y   <= cfg_data;
        cuim_pkg::CFG_BLOCK_LOG2: block_log2 <= cfg_data[cuim_pkg::LOG2_W-1:0];
        cuim_pkg::CFG_CELL_LOG2:  cell_log2  <= cfg_data[cuim_pkg::LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // Bounds arithmetic on the registered request.
  always_comb begin
    usize     = 8'd1 << ulog2_q;
    bsize     = 8'd1 << block_log2;
    x_end     = {1'b0, px_q} + {9'd0, usize};
    y_end     = {1'b0, py_q} + {9'd0, usize};
    blk_x_end = {1'b0, origin_x} + {9'd0, bsize};
    blk_y_end = {1'b0, origin_y} + {9'd0, bsize};
    lo_ok     = (px_q >= origin_x) && (py_q >= origin_y);
    add_fit   = lo_ok && (x_end <= blk_x_end) && (y_end <= blk_y_end);
    look_fit  = lo_ok && ({1'b0, px_q} < blk_x_end) && ({1'b0, py_q} < blk_y_end);
    diff_x    = px_q - origin_x;
    diff_y    = py_q - origin_y;
  end

  // Cell indexes and covered ranges from the offsets inside the block.
  always_comb begin
    cx = dx_q >> cell_log2;
    cy = dy_q >> cell_log2;
    if (ulog2_q >= cell_log2) begin
      count = 8'd1 << (ulog2_q - cell_log2);
    end else begin
      count = 8'd1;
    end
    cx_end = {1'b0, cx} + count;
    cy_end = {1'b0, cy} + count;
  end

  // Row merge: covered columns take the new unit number.
  always_comb begin
    row_old = map_valid[row_q] ? map_rdata : '0;
    row_new = row_old;
    for (int c = 0; c < CELLS_PER_SIDE; c++) begin
      if (col_mask[c]) begin
        row_new[c*cuim_pkg::UNIT_W +: cuim_pkg::UNIT_W] = num_q;
      end
    end
    entry      = row_old[col_q*cuim_pkg::UNIT_W +: cuim_pkg::UNIT_W];
    entry_prow = PROW_W'(entry >> cuim_pkg::PRES_SEL_W);
  end

  // Next state, memory controls and results.
  always_comb begin
    state_next        = state;
    dx_next           = dx_q;
    dy_next           = dy_q;
    row_cur_next      = row_cur;
    row_end_next      = row_end;
    col_mask_next     = col_mask;
    row_q_next        = row_q;
    col_q_next        = col_q;
    wr_pend_next      = 1'b0;
    pres_pend_next    = 1'b0;
    n_next            = n_q;
    done_next         = 1'b0;
    accepted_next     = 1'b0;
    found_next        = 1'b0;
    found_number_next = '0;
    outside_next      = 1'b0;
    clear_all         = 1'b0;
    map_raddr         = row_cur[ROW_W-1:0];
    map_we            = 1'b0;
    map_waddr         = row_q;
    map_wdata         = row_new;
    pres_raddr        = num_prow;
    pres_we           = 1'b0;
    pres_waddr        = num_prow;
    pres_wdata        = (pres_valid[num_prow] ? pres_rdata : '0)
                        | (cuim_pkg::PRES_ROW_W'(1) << num_q[cuim_pkg::PRES_SEL_W-1:0]);

    case (state)
      cuim_pkg::ST_IDLE: begin
        if (take) begin
          case (req_type)
            cuim_pkg::REQ_ADD, cuim_pkg::REQ_LOOKUP: state_next = cuim_pkg::ST_CHECK;
            cuim_pkg::REQ_CLEAR: begin
              clear_all = 1'b1;
              done_next = 1'b1;
            end
            default: done_next = 1'b1;
          endcase
        end
      end

      cuim_pkg::ST_CHECK: begin
        dx_next = diff_x[6:0];
        dy_next = diff_y[6:0];
        if (req_q == cuim_pkg::REQ_ADD) begin
          if (add_fit) begin
            state_next = cuim_pkg::ST_PREP;
          end else begin
            state_next = cuim_pkg::ST_IDLE;
            done_next  = 1'b1;
          end
        end else if (look_fit) begin
          state_next = cuim_pkg::ST_PREP;
        end else begin
          state_next   = cuim_pkg::ST_IDLE;
          done_next    = 1'b1;
          outside_next = 1'b1;
        end
      end

      cuim_pkg::ST_PREP: begin
        if (req_q == cuim_pkg::REQ_ADD) begin
          // Rows covered by the unit, clipped at the grid edge; present row read starts here.
          row_cur_next   = ({1'b0, cy} >= CPS8) ? CPS_C : CNT_W'(cy);
          row_end_next   = (cy_end >= CPS8) ? CPS_C : CNT_W'(cy_end);
          for (int c = 0; c < CELLS_PER_SIDE; c++) begin
            col_mask_next[c] = (8'(c) >= {1'b0, cx}) && (8'(c) < cx_end);
          end
          pres_pend_next = (32'(num_q) < MAX_UNITS);
          state_next     = cuim_pkg::ST_FILL;
        end else if (({1'b0, cx} < CPS8) && ({1'b0, cy} < CPS8)) begin
          map_raddr  = cy[ROW_W-1:0];
          row_q_next = cy[ROW_W-1:0];
          col_q_next = cx[ROW_W-1:0];
          state_next = cuim_pkg::ST_LREAD;
        end else begin
          state_next = cuim_pkg::ST_IDLE;
          done_next  = 1'b1;
        end
      end

      cuim_pkg::ST_FILL: begin
        // Read row r while row r-1, read last cycle, is written back.
        map_we  = wr_pend;
        pres_we = pres_pend;
        if (row_cur < row_end) begin
          map_raddr    = row_cur[ROW_W-1:0];
          row_cur_next = row_cur + CNT_W'(1);
          row_q_next   = row_cur[ROW_W-1:0];
          wr_pend_next = 1'b1;
        end else if (!wr_pend) begin
          state_next    = cuim_pkg::ST_IDLE;
          done_next     = 1'b1;
          accepted_next = 1'b1;
        end
      end

      cuim_pkg::ST_LREAD: begin
        if (32'(entry) < MAX_UNITS) begin
          pres_raddr = entry_prow;
          n_next     = entry;
          state_next = cuim_pkg::ST_LPRES;
        end else begin
          state_next        = cuim_pkg::ST_IDLE;
          done_next         = 1'b1;
          found_number_next = entry;
        end
      end

      cuim_pkg::ST_LPRES: begin
        state_next        = cuim_pkg::ST_IDLE;
        done_next         = 1'b1;
        found_number_next = n_q;
        found_next        = pres_valid[n_prow]
                            && pres_rdata[n_q[cuim_pkg::PRES_SEL_W-1:0]];
      end

      default: state_next = cuim_pkg::ST_IDLE;
    endcase
  end

  // Control state, row valid bits and result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cuim_pkg::ST_IDLE;
      wr_pend    <= 1'b0;
      pres_pend  <= 1'b0;
      map_valid  <= '0;
      pres_valid <= '0;
      done       <= 1'b0;
    end else begin
      state     <= state_next;
      wr_pend   <= wr_pend_next;
      pres_pend <= pres_pend_next;
      done      <= done_next;
      if (clear_all) begin
        map_valid  <= '0;
        pres_valid <= '0;
      end else begin
        if (map_we) begin
          map_valid[map_waddr] <= 1'b1;
        end
        if (pres_we) begin
          pres_valid[pres_waddr] <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      req_q   <= req_type;
      px_q    <= pos_x;
      py_q    <= pos_y;
      ulog2_q <= unit_log2_size;
      num_q   <= unit_number;
    end
    dx_q          <= dx_next;
    dy_q          <= dy_next;
    row_cur       <= row_cur_next;
    row_end       <= row_end_next;
    col_mask      <= col_mask_next;
    row_q         <= row_q_next;
    col_q         <= col_q_next;
    n_q           <= n_next;
    accepted      <= accepted_next;
    found         <= found_next;
    found_number  <= found_number_next;
    outside_block <= outside_next;
  end

  // Map memory: one row of cell numbers per grid row.
  cuim_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (CELLS_PER_SIDE),
    .ADDR_W(ROW_W)
  ) u_map_ram (
    .clk  (clk),
    .we   (map_we),
    .waddr(map_waddr),
    .wdata(map_wdata),
    .raddr(map_raddr),
    .rdata(map_rdata)
  );

  // Present memory: eight unit numbers per row.
  cuim_ram #(
    .WIDTH (cuim_pkg::PRES_ROW_W),
    .DEPTH (PROWS),
    .ADDR_W(PROW_W)
  ) u_pres_ram (
    .clk  (clk),
    .we   (pres_we),
    .waddr(pres_waddr),
    .wdata(pres_wdata),
    .raddr(pres_raddr),
    .rdata(pres_rdata)
  );

  // A result beat ends a request and never overlaps work in progress.
  `CUIM_ASSERT(a_done_idle, done |-> !busy, "result beat while busy")
  `CUIM_ASSERT(a_done_cause, done |-> $past(take) || $past(busy), "result beat without request")
  // Memory write-backs happen only while an add fills rows.
  `CUIM_ASSERT(a_we_in_fill, (map_we || pres_we) |-> state == cuim_pkg::ST_FILL, "write outside fill")
  // Flags match the request type that produced them.
  `CUIM_ASSERT(a_acc_add, (done && accepted) |-> req_q == cuim_pkg::REQ_ADD, "accepted on non-add")
  `CUIM_ASSERT(a_look_flags, (done && (found || outside_block)) |-> req_q == cuim_pkg::REQ_LOOKUP, "lookup flags on non-lookup")
  `CUIM_ASSERT_RST(a_rst_quiet, rst |=> !done && !busy, "activity right after reset")

endmodule

@@ tb/sv/coding_unit_index_map_tb.sv @@
module coding_unit_index_map_tb;

  localparam int CELLS_PER_SIDE = 8;
  localparam int MAX_UNITS = 64;
  localparam int ITEMS_PER_PHASE = 103;
  localparam logic [cuim_pkg::REQ_W-1:0] REQ_UNDEFINED = 2'd3;

  // One request beat and one result beat, field for field.
  typedef struct packed {
    logic [cuim_pkg::REQ_W-1:0]   kind;
    logic [cuim_pkg::COORD_W-1:0] x;
    logic [cuim_pkg::COORD_W-1:0] y;
    logic [cuim_pkg::LOG2_W-1:0]  log2;
    logic [cuim_pkg::UNIT_W-1:0]  number;
  } map_req_t;

  typedef struct packed {
    logic                        accepted;
    logic                        found;
    logic [cuim_pkg::UNIT_W-1:0] number;
    logic                        outside;
  } map_result_t;

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic [cuim_pkg::REQ_W-1:0]     req_type;
  logic [cuim_pkg::COORD_W-1:0]   pos_x;
  logic [cuim_pkg::COORD_W-1:0]   pos_y;
  logic [cuim_pkg::LOG2_W-1:0]    unit_log2_size;
  logic [cuim_pkg::UNIT_W-1:0]    unit_number;
  logic                           done;
  logic                           accepted;
  logic                           found;
  logic [cuim_pkg::UNIT_W-1:0]    found_number;
  logic                           outside_block;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [cuim_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cuim_pkg::COORD_W-1:0]   cfg_data;

  // Shadow copy of the block's registers and map contents.
  int unsigned                 cur_origin_x;
  int unsigned                 cur_origin_y;
  int unsigned                 cur_block_log2;
  int unsigned                 cur_cell_log2;
  logic [cuim_pkg::UNIT_W-1:0] cell_units [CELLS_PER_SIDE][CELLS_PER_SIDE];
  bit                          unit_added [MAX_UNITS];

  map_result_t expected_results[$];
  map_result_t want_result;
  map_result_t seen_result;
  int          failures;
  bit          steady_stream;

  coding_unit_index_map i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .unit_log2_size (unit_log2_size),
    .unit_number    (unit_number),
    .done           (done),
    .accepted       (accepted),
    .found          (found),
    .found_number   (found_number),
    .outside_block  (outside_block),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Empty every cell and drop every present bit.
  function automatic void clear_cells();
    for (int r = 0; r < CELLS_PER_SIDE; r++) begin
      for (int c = 0; c < CELLS_PER_SIDE; c++) begin
        cell_units[r][c] = '0;
      end
    end
    for (int n = 0; n < MAX_UNITS; n++) begin
      unit_added[n] = 1'b0;
    end
  endfunction

  // Apply one request to the shadow map and return the result it must give.
  function automatic map_result_t predict_map_result(map_req_t item);
    map_result_t res;
    int unsigned px, py, usize, bsize, cx, cy, count;
    res = '0;
    px = item.x;
    py = item.y;
    bsize = 32'd1 << cur_block_log2;
    case (item.kind)
      cuim_pkg::REQ_ADD: begin
        usize = 32'd1 << item.log2;
        if (px >= cur_origin_x && px + usize <= cur_origin_x + bsize &&
            py >= cur_origin_y && py + usize <= cur_origin_y + bsize) begin
          cx = (px - cur_origin_x) >> cur_cell_log2;
          cy = (py - cur_origin_y) >> cur_cell_log2;
          count = (item.log2 >= cur_cell_log2) ? (32'd1 << (item.log2 - cur_cell_log2)) : 1;
          // Cells past the edge of the grid are simply not stored.
          for (int unsigned r = cy; r < cy + count && r < CELLS_PER_SIDE; r++) begin
            for (int unsigned c = cx; c < cx + count && c < CELLS_PER_SIDE; c++) begin
              cell_units[r][c] = item.number;
            end
          end
          if (item.number < MAX_UNITS) begin
            unit_added[item.number] = 1'b1;
          end
          res.accepted = 1'b1;
        end
      end
      cuim_pkg::REQ_LOOKUP: begin
        if (px < cur_origin_x || px >= cur_origin_x + bsize ||
            py < cur_origin_y || py >= cur_origin_y + bsize) begin
          res.outside = 1'b1;
        end else begin
          cx = (px - cur_origin_x) >> cur_cell_log2;
          cy = (py - cur_origin_y) >> cur_cell_log2;
          if (cx < CELLS_PER_SIDE && cy < CELLS_PER_SIDE) begin
            res.number = cell_units[cy][cx];
            res.found = (res.number < MAX_UNITS) && unit_added[res.number];
          end
        end
      end
      cuim_pkg::REQ_CLEAR: begin
        clear_cells();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic map_req_t make_request(logic [cuim_pkg::REQ_W-1:0] kind,
                                            logic [cuim_pkg::COORD_W-1:0] x,
                                            logic [cuim_pkg::COORD_W-1:0] y,
                                            logic [cuim_pkg::LOG2_W-1:0] log2,
                                            logic [cuim_pkg::UNIT_W-1:0] number);
    return {kind, x, y, log2, number};
  endfunction

  // Mostly short idle gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_stream || roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  // Random request shaped by the current block: mostly adds and lookups that land
  // inside it, with clears, undefined types and fully random beats mixed in.
  function automatic map_req_t random_request();
    map_req_t item;
    int unsigned bsize, span, roll, top_log2;
    bsize = 32'd1 << cur_block_log2;
    top_log2 = (cur_block_log2 > 3) ? cur_block_log2 : 3;
    roll = $urandom_range(0, 99);
    item.kind = cuim_pkg::REQ_W'($urandom_range(0, 3));
    item.x = cuim_pkg::COORD_W'($urandom_range(0, 65535));
    item.y = cuim_pkg::COORD_W'($urandom_range(0, 65535));
    item.log2 = cuim_pkg::LOG2_W'($urandom_range(0, 7));
    item.number = cuim_pkg::UNIT_W'($urandom_range(0, 63));
    if (roll < 45) begin
      item.kind = cuim_pkg::REQ_ADD;
      if ($urandom_range(0, 9) != 0) begin
        item.log2 = cuim_pkg::LOG2_W'($urandom_range(3, top_log2));
      end
      span = (item.log2 <= cur_block_log2) ? (bsize >> item.log2) : 1;
      item.x = cuim_pkg::COORD_W'(cur_origin_x + ($urandom_range(0, span - 1) << item.log2));
      item.y = cuim_pkg::COORD_W'(cur_origin_y + ($urandom_range(0, span - 1) << item.log2));
      // Now and then the corner is off the unit grid.
      if ($urandom_range(0, 7) == 0) begin
        item.x = item.x + cuim_pkg::COORD_W'($urandom_range(0, 7));
        item.y = item.y + cuim_pkg::COORD_W'($urandom_range(0, 7));
      end
    end else if (roll < 85) begin
      item.kind = cuim_pkg::REQ_LOOKUP;
      item.x = cuim_pkg::COORD_W'(cur_origin_x + $urandom_range(0, bsize - 1));
      item.y = cuim_pkg::COORD_W'(cur_origin_y + $urandom_range(0, bsize - 1));
      case ($urandom_range(0, 15))
        0: item.x = cuim_pkg::COORD_W'(cur_origin_x - 1);
        1: item.y = cuim_pkg::COORD_W'(cur_origin_y + bsize);
        default: begin
        end
      endcase
    end else if (roll < 88) begin
      item.kind = cuim_pkg::REQ_CLEAR;
    end else if (roll < 92) begin
      item.kind = REQ_UNDEFINED;
    end
    return item;
  endfunction

  // Send one request beat. Start stays high on return, so the caller either sends
  // the next beat in the same step or closes the stream with settle_requests.
  task automatic send_request(input map_req_t item);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= item.kind;
    pos_x <= item.x;
    pos_y <= item.y;
    unit_log2_size <= item.log2;
    unit_number <= item.number;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_map_result(item));
  endtask

  // Stop sending and wait until every result is in.
  task automatic settle_requests();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One configuration beat; valid stays high for a following beat.
  task automatic cfg_beat(input logic [cuim_pkg::CFG_IDX_W-1:0] index,
                          input logic [cuim_pkg::COORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      cuim_pkg::CFG_ORIGIN_X:   cur_origin_x = data;
      cuim_pkg::CFG_ORIGIN_Y:   cur_origin_y = data;
      cuim_pkg::CFG_BLOCK_LOG2: cur_block_log2 = data[cuim_pkg::LOG2_W-1:0];
      cuim_pkg::CFG_CELL_LOG2:  cur_cell_log2 = data[cuim_pkg::LOG2_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic write_config(input logic [cuim_pkg::COORD_W-1:0] origin_x,
                              input logic [cuim_pkg::COORD_W-1:0] origin_y,
                              input logic [cuim_pkg::LOG2_W-1:0] block_log2,
                              input logic [cuim_pkg::LOG2_W-1:0] cell_log2);
    cfg_beat(cuim_pkg::CFG_ORIGIN_X, origin_x);
    cfg_beat(cuim_pkg::CFG_ORIGIN_Y, origin_y);
    cfg_beat(cuim_pkg::CFG_BLOCK_LOG2, cuim_pkg::COORD_W'(block_log2));
    cfg_beat(cuim_pkg::CFG_CELL_LOG2, cuim_pkg::COORD_W'(cell_log2));
    cfg_valid <= 1'b0;
  endtask

  // Register values from reset: unwritten cells, full and unaligned adds, a unit
  // smaller than a cell, rejected adds, outside lookups, clear and an undefined type.
  task automatic test_reset_defaults();
    send_request(make_request(cuim_pkg::REQ_LOOKUP, 16'd0, 16'd0, 3'd0, 6'd0));
    send_request(make_request(cuim_pkg::REQ_ADD, 16'd0, 16'd0, 3'd6, 6'd63));
    send_request(make_request(cuim_pkg::REQ_LOOKUP, 16'd63, 16'd63, 3'd0, 6'd0));
    send_request(make_request(cuim_pkg::REQ_ADD, 16'd12, 16'd20, 3'd4, 6'd5));
    send_request(make_request(cuim_pkg::REQ_LOOKUP, 16'd16, 16'd24, 3'd0, 6'd0));
    send_request(make_request(cuim_pkg::REQ_ADD, 16'd8, 16'd0, 3'd6, 6'd1));
    send_request(make_request(cuim_pkg::REQ_ADD, 16'd5, 16'd5, 3'd0, 6'd0));
    send_request(make_request(cuim_pkg::REQ_LOOKUP, 16'd0, 16'd7, 3'd0, 6'd0));
    send_request(make_request(cuim_pkg::REQ_LOOKUP, 16'd64, 16'd0, 3'd0, 6'd0));
    send_request(make_request(cuim_pkg::REQ_LOOKUP, 16'd0, 16'hffff, 3'd0, 6'd0));
    send_request(make_request(REQ_UNDEFINED, 16'hffff, 16'hffff, 3'd7, 6'd63));
    send_request(make_request(cuim_pkg::REQ_CLEAR, 16'd0, 16'd0, 3'd0, 6'd0));
    send_request(make_request(cuim_pkg::REQ_LOOKUP, 16'd63, 16'd63, 3'd0, 6'd0));
    settle_requests();
  endtask

  // Tree block against the top of the coordinate range, cells larger than the unit.
  task automatic test_origin_extremes();
    write_config(16'hffc0, 16'hffc0, 3'd6, 3'd4);
    send_request(make_request(cuim_pkg::REQ_ADD, 16'hffbf, 16'hffc0, 3'd3, 6'd2));
    send_request(make_request(cuim_pkg::REQ_ADD, 16'hfff8, 16'hfff8, 3'd3, 6'd42));
    send_request(make_request(cuim_pkg::REQ_LOOKUP, 16'hffff, 16'hffff, 3'd0, 6'd0));
    send_request(make_request(cuim_pkg::REQ_LOOKUP, 16'hffbf, 16'hffc0, 3'd0, 6'd0));
    settle_requests();
  endtask

  // A tree block wider than the grid: adds and lookups past the last cell.
  task automatic test_beyond_grid();
    write_config(16'd0, 16'd0, 3'd7, 3'd3);
    send_request(make_request(cuim_pkg::REQ_ADD, 16'd0, 16'd0, 3'd7, 6'd9));
    send_request(make_request(cuim_pkg::REQ_LOOKUP, 16'd100, 16'd100, 3'd0, 6'd0));
    send_request(make_request(cuim_pkg::REQ_LOOKUP, 16'd60, 16'd60, 3'd0, 6'd0));
    send_request(make_request(cuim_pkg::REQ_ADD, 16'd64, 16'd64, 3'd6, 6'd10));
    send_request(make_request(cuim_pkg::REQ_LOOKUP, 16'd127, 16'd0, 3'd0, 6'd0));
    send_request(make_request(cuim_pkg::REQ_ADD, 16'd0, 16'd0, 3'd6, 6'd33));
    send_request(make_request(cuim_pkg::REQ_LOOKUP, 16'd8, 16'd8, 3'd0, 6'd0));
    settle_requests();
  endtask

  // Random traffic over a series of block settings, extremes among them.
  task automatic test_random_phases();
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: write_config(16'd0, 16'd0, 3'd6, 3'd3);
        1: write_config(16'hffc0, 16'hffc0, 3'd6, 3'd3);
        2: write_config(16'($urandom_range(0, 65407)), 16'($urandom_range(0, 65407)), 3'd3, 3'd3);
        3: write_config(16'hffff, 16'hffff, 3'd6, 3'd6);
        4: write_config(16'($urandom_range(0, 65407)), 16'($urandom_range(0, 65407)), 3'd6, 3'd4);
        5: write_config(16'($urandom_range(0, 65407)), 16'($urandom_range(0, 65407)), 3'd5, 3'd3);
        6: write_config(16'($urandom_range(0, 65407)), 16'($urandom_range(0, 65407)), 3'd4, 3'd5);
        7: write_config(16'($urandom_range(0, 65407)), 16'($urandom_range(0, 65407)), 3'd7, 3'd3);
        8: write_config(16'($urandom_range(0, 65407)), 16'($urandom_range(0, 65407)),
                        3'($urandom_range(3, 6)), 3'($urandom_range(3, 6)));
        default: write_config(16'($urandom_range(0, 65407)), 16'($urandom_range(0, 65407)),
                              3'd6, 3'd0);
      endcase
      steady_stream = (p % 3 == 1);
      repeat (ITEMS_PER_PHASE) send_request(random_request());
      settle_requests();
    end
    steady_stream = 1'b0;
  endtask

  // Each result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      seen_result = {accepted, found, found_number, outside_block};
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected result beat: accepted %0b found %0b number %0d outside %0b",
                   accepted, found, found_number, outside_block);
        end
      end else begin
        want_result = expected_results.pop_front();
        if (seen_result !== want_result) begin
          failures++;
          if (failures <= 10) begin
            $display("mismatch: expected accepted %0b found %0b number %0d outside %0b",
                     want_result.accepted, want_result.found, want_result.number,
                     want_result.outside);
            $display("          got      accepted %0b found %0b number %0d outside %0b",
                     accepted, found, found_number, outside_block);
          end
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req_type = cuim_pkg::REQ_ADD;
    pos_x = '0;
    pos_y = '0;
    unit_log2_size = '0;
    unit_number = '0;
    cfg_valid = 1'b0;
    cfg_index = cuim_pkg::CFG_ORIGIN_X;
    cfg_data = '0;
    failures = 0;
    steady_stream = 1'b0;
    cur_origin_x = 0;
    cur_origin_y = 0;
    cur_block_log2 = cuim_pkg::BLOCK_LOG2_RESET;
    cur_cell_log2 = cuim_pkg::CELL_LOG2_RESET;
    clear_cells();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_origin_extremes();
    test_beyond_grid();
    test_random_phases();

    // Drain whatever is still in flight, with a bound.
    for (int n = 0; n < 400 && expected_results.size() != 0; n++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (expected_results.size() != 0) begin
      failures += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
